// ===== rtl/core/heap_file_page_allocator_core_assert.svh =====
// assertion macros shared by the allocator rtl
`ifndef HEAP_FILE_PAGE_ALLOCATOR_CORE_ASSERT_SVH
`define HEAP_FILE_PAGE_ALLOCATOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HFPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HFPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HFPA_ASSERT(lbl, prop, msg)
`define HFPA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/hfpa_pkg.sv =====
package hfpa_pkg;

  localparam int PAGE_HEADER_BYTES = 16;
  localparam int SLOT_COST_BYTES   = 4;
  localparam int ROOM_W            = 18;
  localparam int COST_W            = 17;
  localparam logic [15:0] CAP_RESET = 16'd4096;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_STATUS = 2'd1,
    OP_FIND   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_INSERTED   = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_PAGE_TOTAL = 3'd2,
    KIND_PAGE_COUNT = 3'd3,
    KIND_FOUND      = 3'd4,
    KIND_NOT_FOUND  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CHK,
    S_INS_NEW,
    S_ST_HDR,
    S_ST_RD,
    S_ST_EMIT,
    S_FD_PRD,
    S_FD_PCHK,
    S_FD_KRD,
    S_FD_KCHK,
    S_FD_MISS
  } state_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [32:0] diff;
    logic        ge;
    logic        eq;
  } alu_res_t;

endpackage

// ===== rtl/core/hfpa_ram.sv =====
module hfpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/hfpa_alu.sv =====
module hfpa_alu (
  input  hfpa_pkg::alu_req_t req,
  output hfpa_pkg::alu_res_t res
);

  import hfpa_pkg::*;

  // one subtractor serves the room check, the new-page room and the key compare
  always_comb begin
    res.diff = {req.a[31], req.a} - {req.b[31], req.b};
    res.ge   = !res.diff[32];
    res.eq   = (res.diff == 33'd0);
  end

endmodule

// ===== rtl/core/heap_file_page_allocator_core.sv =====
// heap file page allocator, first-fit record placement
// input channel (in_valid/in_ready) carries operation, record_size and key;
// result channel (out_valid/out_ready) carries kind, page_index, slot_index,
// count and last. in_ready is high only while the sequencer is idle, one item
// is worked at a time. the result sits in an output register, so the next
// item is taken while the last result still waits for the receiver.
// insert scans the pages in order for one with room and a free slot, else
// appends a new page (or reports full); status gives the page total, then
// one result per page; find scans the stored keys page by page and gives a
// not-found result when no key matches. one shared subtractor does the room
// checks and the key compare. each scan step waits on a registered read of
// the page table or the key memory.
// a stalled receiver holds the sequencer at the result it wants to present.
// reset (rst_n low at a clock edge) empties the heap and sets the capacity
// register to 4096; memory contents are not cleared, pages beyond the count
// are never read. cfg_we writes the capacity register; it affects pages
// created afterwards.
`include "heap_file_page_allocator_core_assert.svh"

module heap_file_page_allocator_core #(
  parameter int MAX_PAGES      = 16,
  parameter int SLOTS_PER_PAGE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_operation,
  input  logic [15:0]        in_record_size,
  input  logic signed [31:0] in_key,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [3:0]         out_page_index,
  output logic [5:0]         out_slot_index,
  output logic [6:0]         out_count,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  import hfpa_pkg::*;

  localparam int PW     = $clog2(MAX_PAGES + 1);
  localparam int SW     = $clog2(SLOTS_PER_PAGE + 1);
  localparam int PAW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int KDEPTH = MAX_PAGES * SLOTS_PER_PAGE;
  localparam int KAW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int PGW    = ROOM_W + SW;

  state_t state_r, state_nxt;

  logic [15:0]        cap_r;
  logic [PW-1:0]      pages_r, pages_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic [SW-1:0]      slot_r, slot_nxt;
  logic [SW-1:0]      cnt_r, cnt_nxt;
  logic signed [31:0] key_r;
  logic [COST_W-1:0]  cost_r;
  logic [ROOM_W-1:0]  tot_r;

  logic       out_valid_r;
  kind_t      out_kind_r, out_kind_nxt;
  logic [3:0] out_page_r, out_page_nxt;
  logic [5:0] out_slot_r, out_slot_nxt;
  logic [6:0] out_count_r, out_count_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_load;
  logic       out_free;
  logic       in_acc;

  logic              pg_we;
  logic [PAW-1:0]    pg_waddr;
  logic [PGW-1:0]    pg_wdata;
  logic [PGW-1:0]    pg_rdata;
  logic signed [ROOM_W-1:0] pg_room;
  logic [SW-1:0]     pg_cnt;

  logic              kr_we;
  logic [KAW-1:0]    kr_waddr;
  logic [KAW-1:0]    kr_raddr;
  logic [31:0]       kr_rdata;

  alu_req_t alu_req;
  alu_res_t alu_res;
  logic     room_fit;
  logic     ptr_at_end;
  logic     heap_full;
  logic     append_go;
  logic     scan_st;

  function automatic logic [KAW-1:0] key_addr(input logic [PW-1:0] pg,
                                              input logic [SW-1:0] sl);
    key_addr = KAW'(pg) * KAW'(SLOTS_PER_PAGE) + KAW'(sl);
  endfunction

  hfpa_ram #(.WIDTH(PGW), .DEPTH(MAX_PAGES)) u_page_ram (
    .clk   (clk),
    .we    (pg_we),
    .waddr (pg_waddr),
    .wdata (pg_wdata),
    .raddr (ptr_r[PAW-1:0]),
    .rdata (pg_rdata)
  );

  hfpa_ram #(.WIDTH(32), .DEPTH(KDEPTH)) u_key_ram (
    .clk   (clk),
    .we    (kr_we),
    .waddr (kr_waddr),
    .wdata (key_r),
    .raddr (kr_raddr),
    .rdata (kr_rdata)
  );

  hfpa_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign pg_room    = pg_rdata[PGW-1:SW];
  assign pg_cnt     = pg_rdata[SW-1:0];
  assign kr_raddr   = key_addr(ptr_r, slot_r);
  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign room_fit   = alu_res.ge && (pg_cnt < SW'(SLOTS_PER_PAGE));
  assign ptr_at_end = ((ptr_r + PW'(1)) == pages_r);
  assign heap_full  = (pages_r == PW'(MAX_PAGES));
  assign append_go  = (state_r == S_INS_NEW) && out_free && !heap_full;
  assign scan_st    = (state_r == S_INS_CHK) || (state_r == S_FD_PCHK) ||
                      (state_r == S_FD_KCHK) || (state_r == S_ST_EMIT);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_t'(in_operation))
            OP_INSERT: state_nxt = (pages_r == '0) ? S_INS_NEW : S_INS_RD;
            OP_STATUS: state_nxt = S_ST_HDR;
            OP_FIND:   state_nxt = (pages_r == '0) ? S_FD_MISS : S_FD_PRD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: state_nxt = S_INS_CHK;
      S_INS_CHK: begin
        if (room_fit) begin
          state_nxt = out_free ? S_IDLE : S_INS_CHK;
        end else begin
          state_nxt = ptr_at_end ? S_INS_NEW : S_INS_RD;
        end
      end
      S_INS_NEW: state_nxt = out_free ? S_IDLE : S_INS_NEW;
      S_ST_HDR: begin
        if (out_free) begin
          state_nxt = (pages_r == '0) ? S_IDLE : S_ST_RD;
        end
      end
      S_ST_RD: state_nxt = S_ST_EMIT;
      S_ST_EMIT: begin
        if (out_free) begin
          state_nxt = ptr_at_end ? S_IDLE : S_ST_RD;
        end
      end
      S_FD_PRD: state_nxt = S_FD_PCHK;
      S_FD_PCHK: begin
        if (pg_cnt == '0) begin
          state_nxt = ptr_at_end ? S_FD_MISS : S_FD_PRD;
        end else begin
          state_nxt = S_FD_KRD;
        end
      end
      S_FD_KRD: state_nxt = S_FD_KCHK;
      S_FD_KCHK: begin
        if (alu_res.eq) begin
          state_nxt = out_free ? S_IDLE : S_FD_KCHK;
        end else if ((slot_r + SW'(1)) == cnt_r) begin
          state_nxt = ptr_at_end ? S_FD_MISS : S_FD_PRD;
        end else begin
          state_nxt = S_FD_KRD;
        end
      end
      S_FD_MISS: state_nxt = out_free ? S_IDLE : S_FD_MISS;
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath controls and results
  always_comb begin
    out_load      = 1'b0;
    out_kind_nxt  = KIND_INSERTED;
    out_page_nxt  = '0;
    out_slot_nxt  = '0;
    out_count_nxt = '0;
    out_last_nxt  = 1'b0;
    pg_we         = 1'b0;
    pg_waddr      = ptr_r[PAW-1:0];
    pg_wdata      = '0;
    kr_we         = 1'b0;
    kr_waddr      = '0;
    alu_req.a     = 32'(pg_room);
    alu_req.b     = 32'(cost_r);
    ptr_nxt       = ptr_r;
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    pages_nxt     = pages_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ptr_nxt  = '0;
          slot_nxt = '0;
        end
      end
      S_INS_RD: ;
      S_INS_CHK: begin
        if (room_fit) begin
          if (out_free) begin
            pg_we        = 1'b1;
            pg_wdata     = {alu_res.diff[ROOM_W-1:0], pg_cnt + SW'(1)};
            kr_we        = 1'b1;
            kr_waddr     = key_addr(ptr_r, pg_cnt);
            out_load     = 1'b1;
            out_kind_nxt = KIND_INSERTED;
            out_page_nxt = 4'(ptr_r);
            out_slot_nxt = 6'(pg_cnt);
            out_last_nxt = 1'b1;
          end
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      S_INS_NEW: begin
        // new page room is capacity less header less this record's cost
        alu_req.a = 32'(cap_r);
        alu_req.b = 32'(tot_r);
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          if (heap_full) begin
            out_kind_nxt = KIND_FULL;
          end else begin
            pg_we        = 1'b1;
            pg_waddr     = pages_r[PAW-1:0];
            pg_wdata     = {alu_res.diff[ROOM_W-1:0], SW'(1)};
            kr_we        = 1'b1;
            kr_waddr     = key_addr(pages_r, '0);
            pages_nxt    = pages_r + PW'(1);
            out_kind_nxt = KIND_INSERTED;
            out_page_nxt = 4'(pages_r);
          end
        end
      end
      S_ST_HDR: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_PAGE_TOTAL;
          out_count_nxt = 7'(pages_r);
          out_last_nxt  = (pages_r == '0);
        end
      end
      S_ST_RD: ;
      S_ST_EMIT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_kind_nxt  = KIND_PAGE_COUNT;
          out_page_nxt  = 4'(ptr_r);
          out_count_nxt = 7'(pg_cnt);
          out_last_nxt  = ptr_at_end;
          ptr_nxt       = ptr_r + PW'(1);
        end
      end
      S_FD_PRD: ;
      S_FD_PCHK: begin
        cnt_nxt  = pg_cnt;
        slot_nxt = '0;
        if (pg_cnt == '0) begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end
      S_FD_KRD: ;
      S_FD_KCHK: begin
        alu_req.a = key_r;
        alu_req.b = kr_rdata;
        if (alu_res.eq) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_kind_nxt = KIND_FOUND;
            out_page_nxt = 4'(ptr_r);
            out_slot_nxt = 6'(slot_r);
            out_last_nxt = 1'b1;
          end
        end else begin
          slot_nxt = slot_r + SW'(1);
          if ((slot_r + SW'(1)) == cnt_r) begin
            ptr_nxt = ptr_r + PW'(1);
          end
        end
      end
      S_FD_MISS: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_nxt = KIND_NOT_FOUND;
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pages_r     <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pages_r <= pages_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r  <= ptr_nxt;
    slot_r <= slot_nxt;
    cnt_r  <= cnt_nxt;
    if (in_acc) begin
      key_r  <= in_key;
      cost_r <= COST_W'(in_record_size) + COST_W'(SLOT_COST_BYTES);
      tot_r  <= ROOM_W'(in_record_size) + ROOM_W'(PAGE_HEADER_BYTES + SLOT_COST_BYTES);
    end
    if (out_load) begin
      out_kind_r  <= out_kind_nxt;
      out_page_r  <= out_page_nxt;
      out_slot_r  <= out_slot_nxt;
      out_count_r <= out_count_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_page_index = out_page_r;
  assign out_slot_index = out_slot_r;
  assign out_count      = out_count_r;
  assign out_last       = out_last_r;

  `HFPA_ASSERT(a_pages_bound, pages_r <= PW'(MAX_PAGES), "page count beyond limit")
  `HFPA_ASSERT(a_append_bumps, append_go |=> (pages_r == $past(pages_r) + PW'(1)), "no page added")
  `HFPA_ASSERT(a_pages_steady, (state_r != S_INS_NEW) |=> $stable(pages_r), "page count moved")
  `HFPA_ASSERT(a_scan_in_heap, scan_st |-> (ptr_r < pages_r), "scan pointer past used pages")
  `HFPA_ASSERT(a_last_ends_item, (out_load && out_last_nxt) |=> in_ready, "item not ended")

endmodule
